>>> hw/rtl/tap_pkg.sv
`default_nettype none

package tap_pkg;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int DEB_W = 10;
  localparam int DUTY_W = 8;
  localparam int STATUS_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SCALED_MIN_W = 32;

  localparam int ROT_BITS_DEF = 20;

  // one full turn in hundredths of a degree
  localparam logic [ANGLE_W-1:0] FULL_TURN = 16'd36000;

  // operation codes
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_CAL = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_ANGLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE = 3'd7;

  // register reset values
  localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 16'd0;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 16'd36000;
  localparam logic [ANGLE_W-1:0] DEADBAND_RST = 16'd500;
  localparam logic [15:0] MIN_RUN_RST = 16'd1000;
  localparam logic [SCALED_MIN_W-1:0] MIN_RUN_SCALED_RST = 32'd36000000;
  localparam logic [ANGLE_W-1:0] SAFE_ANGLE_RST = 16'd500;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 10'd100;
  localparam logic [DUTY_W-1:0] DRIVE_SPEED_RST = 8'd255;
  localparam logic [15:0] PAUSE_RST = 16'd3000;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_CAL_RIGHT  = 3'd1,
    MODE_CAL_PAUSE  = 3'd2,
    MODE_CAL_LEFT   = 3'd3,
    MODE_HOME_LEFT  = 3'd4,
    MODE_MOVE_LEFT  = 3'd5,
    MODE_MOVE_RIGHT = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE       = 4'd0,
    ST_MOVED      = 4'd1,
    ST_DEADBAND   = 4'd2,
    ST_TOO_SHORT  = 4'd3,
    ST_PARKED     = 4'd4,
    ST_LIMIT      = 4'd5,
    ST_CALIBRATED = 4'd6,
    ST_NOT_CAL    = 4'd8
  } status_t;

  // verdict of the move planner
  typedef struct packed {
    logic in_deadband;
    logic too_short;
    logic zero_run;
    logic go_right;
  } plan_t;

endpackage

`default_nettype wire

>>> hw/rtl/tap_debounce.sv
`default_nettype none

module tap_debounce
  import tap_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             raw_level,
  input  wire logic [DEB_W-1:0] debounce_ticks,
  output logic                  press
);

  localparam logic [DEB_W-1:0] COUNT_MAX = '1;

  logic             stable_r, stable_nxt;
  logic [DEB_W-1:0] count_r, count_nxt;
  logic [DEB_W-1:0] count_inc;
  logic             differ;
  logic             take;

  // count ticks of a differing level, accept once it has lasted long enough
  always_comb begin
    differ    = raw_level != stable_r;
    count_inc = (count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;
    take      = differ && (count_inc >= debounce_ticks);
    press     = take && raw_level;
    stable_nxt = stable_r;
    count_nxt  = count_inc;
    if (!differ) begin
      count_nxt = '0;
    end else if (take) begin
      count_nxt  = '0;
      stable_nxt = raw_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      count_r  <= '0;
    end else if (step) begin
      stable_r <= stable_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tap_move_plan.sv
`default_nettype none

module tap_move_plan
  import tap_pkg::*;
#(
  parameter int ROTATION_COUNT_BITS = ROT_BITS_DEF
) (
  input  wire logic [ANGLE_W-1:0]                     target,
  input  wire logic [ANGLE_W-1:0]                     start_pos,
  input  wire logic [ROTATION_COUNT_BITS-1:0]         rotation,
  input  wire logic [ANGLE_W-1:0]                     deadband,
  input  wire logic [SCALED_MIN_W-1:0]                min_run_scaled,
  output plan_t                                       plan,
  output logic [ANGLE_W+ROTATION_COUNT_BITS-1:0]      run_scaled
);

  localparam int PW = ANGLE_W + ROTATION_COUNT_BITS;
  localparam int CMPW = (PW > SCALED_MIN_W) ? PW : SCALED_MIN_W;
  // longest run, kept in the scaled (ticks * full turn) domain
  localparam logic [PW-1:0] RUN_MAX_SCALED =
    PW'(FULL_TURN) * PW'((64'd1 << ROTATION_COUNT_BITS) - 64'd1);

  logic [ANGLE_W-1:0] diff;
  logic [PW-1:0]      prod;

  // run time is tracked as diff * rotation and counted down a full turn per tick
  always_comb begin
    diff = (target > start_pos) ? target - start_pos : start_pos - target;
    prod = PW'(diff) * PW'(rotation);
    plan.in_deadband = diff < deadband;
    plan.too_short   = CMPW'(prod) < CMPW'(min_run_scaled);
    plan.zero_run    = prod < PW'(FULL_TURN);
    plan.go_right    = target > start_pos;
    run_scaled       = (prod > RUN_MAX_SCALED) ? RUN_MAX_SCALED : prod;
  end

endmodule

`default_nettype wire

>>> hw/rtl/timed_axis_positioner_top.sv
// Latency: a result word is valid in the cycle after its input word is accepted.
// Throughput: one input word per clock cycle unless stalled; the sequencer state,
// debouncer and move planner all settle in the single pass between accept and
// result register. An input word is refused only while a result word waits and
// out_stall is high. Reset: rst_n is synchronous and active low; it returns the axis
// to idle, uncalibrated at angle zero, and loads the register defaults.
`default_nettype none

module timed_axis_positioner_top
  import tap_pkg::*;
#(
  parameter int ROTATION_COUNT_BITS = ROT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_operation,
  input  wire logic [ANGLE_W-1:0]    in_target_angle,
  input  wire logic                  in_switch_level,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_motor_enable,
  output logic                       out_motor_direction,
  output logic [DUTY_W-1:0]          out_pwm_duty,
  output logic                       out_busy_res,
  output logic [ANGLE_W-1:0]         out_position,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int CW = ROTATION_COUNT_BITS;
  localparam int PW = ANGLE_W + CW;
  localparam int PSW = CW + 16;
  localparam logic [CW-1:0] CNT_MAX = '1;

  // configuration registers
  logic [ANGLE_W-1:0]      min_angle_r, max_angle_r, deadband_r, safe_angle_r;
  logic [SCALED_MIN_W-1:0] min_run_scaled_r;
  logic [DEB_W-1:0]        debounce_r;
  logic [DUTY_W-1:0]       drive_speed_r;
  logic [15:0]             pause_r;

  // sequencer state
  mode_t              mode_r, mode_nxt;
  logic [ANGLE_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]      rot_r, rot_nxt;
  logic [CW-1:0]      cal_cnt_r, cal_cnt_nxt;
  logic [PW-1:0]      move_cnt_r, move_cnt_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic                en_r, dir_r, busy_r;
  logic [DUTY_W-1:0]   duty_r;
  logic [ANGLE_W-1:0]  position_r;
  status_t             status_r;

  logic               in_acc;
  logic               press;
  logic               do_plan;
  logic               home_plan;
  logic [ANGLE_W-1:0] plan_tgt, plan_pos;
  plan_t              plan;
  logic [PW-1:0]      run_scaled;
  logic [CW-1:0]      pause_sat;
  logic [CW-1:0]      cal_dec, cal_inc;
  logic [PW-1:0]      move_left;
  status_t            status;
  logic               en, dir;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // configuration writes; the minimum run is kept pre-scaled by a full turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_angle_r      <= MIN_ANGLE_RST;
      max_angle_r      <= MAX_ANGLE_RST;
      deadband_r       <= DEADBAND_RST;
      min_run_scaled_r <= MIN_RUN_SCALED_RST;
      safe_angle_r     <= SAFE_ANGLE_RST;
      debounce_r       <= DEBOUNCE_RST;
      drive_speed_r    <= DRIVE_SPEED_RST;
      pause_r          <= PAUSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_ANGLE:   min_angle_r <= cfg_wdata;
        REG_MAX_ANGLE:   max_angle_r <= cfg_wdata;
        REG_DEADBAND:    deadband_r <= cfg_wdata;
        REG_MIN_RUN:     min_run_scaled_r <=
                           SCALED_MIN_W'(cfg_wdata) * SCALED_MIN_W'(FULL_TURN);
        REG_SAFE_ANGLE:  safe_angle_r <= cfg_wdata;
        REG_DEBOUNCE:    debounce_r <= cfg_wdata[DEB_W-1:0];
        REG_DRIVE_SPEED: drive_speed_r <= cfg_wdata[DUTY_W-1:0];
        REG_PAUSE:       pause_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  tap_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (in_acc),
    .raw_level      (in_switch_level),
    .debounce_ticks (debounce_r),
    .press          (press)
  );

  // after homing the plan runs from zero to the parking angle
  assign home_plan = mode_r == MODE_HOME_LEFT;
  assign plan_tgt  = home_plan ? safe_angle_r : in_target_angle;
  assign plan_pos  = home_plan ? '0 : pos_r;

  tap_move_plan #(
    .ROTATION_COUNT_BITS (ROTATION_COUNT_BITS)
  ) u_move_plan (
    .target         (plan_tgt),
    .start_pos      (plan_pos),
    .rotation       (rot_r),
    .deadband       (deadband_r),
    .min_run_scaled (min_run_scaled_r),
    .plan           (plan),
    .run_scaled     (run_scaled)
  );

  // sequencer next state and result
  always_comb begin
    pause_sat = (PSW'(pause_r) > PSW'(CNT_MAX)) ? CNT_MAX : CW'(pause_r);
    cal_dec   = (cal_cnt_r != '0) ? cal_cnt_r - 1'b1 : cal_cnt_r;
    cal_inc   = (cal_cnt_r != CNT_MAX) ? cal_cnt_r + 1'b1 : cal_cnt_r;
    move_left = move_cnt_r - PW'(FULL_TURN);

    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    rot_nxt      = rot_r;
    cal_cnt_nxt  = cal_cnt_r;
    move_cnt_nxt = move_cnt_r;
    status       = ST_NONE;
    do_plan      = 1'b0;

    case (mode_r)
      MODE_IDLE: begin
        if (in_operation == OP_CAL) begin
          mode_nxt = MODE_CAL_RIGHT;
        end else if (in_operation == OP_MOVE) begin
          if (rot_r == '0) begin
            status = ST_NOT_CAL;
          end else if (in_target_angle < min_angle_r || in_target_angle > max_angle_r) begin
            if (pos_r == safe_angle_r) begin
              status = ST_PARKED;
            end else begin
              mode_nxt = MODE_HOME_LEFT;
            end
          end else begin
            do_plan = 1'b1;
          end
        end
      end
      MODE_CAL_RIGHT: begin
        if (press) begin
          pos_nxt     = FULL_TURN;
          cal_cnt_nxt = pause_sat;
          mode_nxt    = (pause_sat == '0) ? MODE_CAL_LEFT : MODE_CAL_PAUSE;
        end
      end
      MODE_CAL_PAUSE: begin
        cal_cnt_nxt = cal_dec;
        if (cal_dec == '0) begin
          mode_nxt = MODE_CAL_LEFT;
        end
      end
      MODE_CAL_LEFT: begin
        cal_cnt_nxt = cal_inc;
        if (press) begin
          rot_nxt     = (cal_inc == '0) ? CW'(1) : cal_inc;
          pos_nxt     = '0;
          cal_cnt_nxt = '0;
          mode_nxt    = MODE_IDLE;
          status      = ST_CALIBRATED;
        end
      end
      MODE_HOME_LEFT: begin
        if (press) begin
          pos_nxt  = '0;
          mode_nxt = MODE_IDLE;
          do_plan  = 1'b1;
        end
      end
      MODE_MOVE_LEFT, MODE_MOVE_RIGHT: begin
        if (press) begin
          pos_nxt  = (mode_r == MODE_MOVE_RIGHT) ? FULL_TURN : '0;
          mode_nxt = MODE_IDLE;
          status   = ST_LIMIT;
        end else begin
          move_cnt_nxt = move_left;
          if (move_left < PW'(FULL_TURN)) begin
            mode_nxt = MODE_IDLE;
            status   = ST_MOVED;
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    // outcome of a planned move
    if (do_plan) begin
      if (plan.in_deadband) begin
        status = ST_DEADBAND;
      end else if (plan.too_short) begin
        status = ST_TOO_SHORT;
      end else begin
        pos_nxt = plan_tgt;
        if (plan.zero_run) begin
          status = ST_MOVED;
        end else begin
          move_cnt_nxt = run_scaled;
          mode_nxt     = plan.go_right ? MODE_MOVE_RIGHT : MODE_MOVE_LEFT;
        end
      end
    end

    en = mode_nxt == MODE_CAL_RIGHT || mode_nxt == MODE_CAL_LEFT ||
         mode_nxt == MODE_HOME_LEFT || mode_nxt == MODE_MOVE_LEFT ||
         mode_nxt == MODE_MOVE_RIGHT;
    dir = mode_nxt == MODE_CAL_RIGHT || mode_nxt == MODE_MOVE_RIGHT;

    out_valid_nxt = in_acc ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      rot_r       <= '0;
      cal_cnt_r   <= '0;
      move_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        mode_r     <= mode_nxt;
        pos_r      <= pos_nxt;
        rot_r      <= rot_nxt;
        cal_cnt_r  <= cal_cnt_nxt;
        move_cnt_r <= move_cnt_nxt;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      en_r       <= en;
      dir_r      <= dir;
      duty_r     <= en ? drive_speed_r : '0;
      busy_r     <= mode_nxt != MODE_IDLE;
      position_r <= pos_nxt;
      status_r   <= status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_motor_enable    = en_r;
  assign out_motor_direction = dir_r;
  assign out_pwm_duty        = duty_r;
  assign out_busy_res        = busy_r;
  assign out_position        = position_r;
  assign out_status          = status_r;

`ifndef SYNTHESIS
  // once calibrated the axis stays calibrated
  a_rot_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (rot_r != '0) |=> (rot_r != '0))
    else $error("rotation time lost after calibration");

  // a running move always has at least one tick left
  a_move_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_MOVE_LEFT || mode_r == MODE_MOVE_RIGHT) |->
    (move_cnt_r >= PW'(FULL_TURN)))
    else $error("move counter below one tick while running");

  // finishing calibration leaves the axis idle at zero
  a_cal_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status == ST_CALIBRATED) |->
    (out_position == '0 && !out_busy_res && !out_motor_enable))
    else $error("calibration result inconsistent");

  // no duty while the driver is off
  a_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_motor_enable) |-> (out_pwm_duty == '0))
    else $error("pwm duty with motor disabled");
`endif

endmodule

`default_nettype wire
